// File: src/bpc_pkg.sv
// Shared types and constants for the button press classifier.
`timescale 1ns / 1ps

package bpc_pkg;

    localparam int WindowWidth    = 10;
    localparam int ThresholdWidth = 8;
    localparam int HoldWidth      = 8;
    localparam int CountWidth     = 11;
    localparam int EventWidth     = 3;
    localparam int CfgIndexWidth  = 1;
    localparam int CfgDataWidth   = 10;

    localparam logic [HoldWidth-1:0]  HoldMax   = '1;
    localparam logic [CountWidth-1:0] CountIdle = '1;   // -1, window idle

    typedef enum logic [CfgIndexWidth-1:0] {
        REG_DOUBLE_WINDOW  = 1'b0,
        REG_LONG_THRESHOLD = 1'b1
    } cfg_index_t;

    typedef enum logic [EventWidth-1:0] {
        EV_NONE    = 3'd0,
        EV_PRESSED = 3'd1,
        EV_SHORT   = 3'd2,
        EV_DOUBLE  = 3'd3,
        EV_LONG    = 3'd4
    } event_t;

    typedef struct packed {
        logic [WindowWidth-1:0]    double_window;
        logic [ThresholdWidth-1:0] long_threshold;
    } cfg_t;

endpackage

// File: src/bpc_core.sv
// Classifier state (hold counter, double-click countdown) and event decode.
`timescale 1ns / 1ps

module bpc_core
    import bpc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  cfg_t   cfg,
    input  logic   sample_en,
    input  logic   pin_level,
    output event_t event_out
);

    logic [HoldWidth-1:0]         hold_reg, hold_next;
    logic signed [CountWidth-1:0] count_reg, count_next;
    logic                         second_reg, second_next;

    logic signed [CountWidth-1:0] window_ext;
    logic signed [CountWidth-1:0] count_dec;
    logic [HoldWidth-1:0]         hold_inc;
    logic                         pressed;

    assign pressed    = !pin_level;
    assign window_ext = $signed({1'b0, cfg.double_window});
    assign hold_inc   = (hold_reg == HoldMax) ? hold_reg : hold_reg + 1'b1;
    assign count_dec  = (count_reg >= 0) ? count_reg - $signed(CountWidth'(1)) : count_reg;

    always_comb
    begin
        hold_next   = hold_reg;
        count_next  = count_reg;
        second_next = second_reg;
        event_out   = EV_NONE;
        if (pressed)
        begin
            if (count_reg <= 0 || count_reg == window_ext)
            begin
                count_next = window_ext;
            end
            else
            begin
                second_next = 1'b1;
            end
            hold_next = hold_inc;
            if (hold_inc >= cfg.long_threshold)
            begin
                event_out  = EV_LONG;
                count_next = CountIdle;
            end
            else
            begin
                event_out = EV_PRESSED;
            end
        end
        else if (second_reg)
        begin
            second_next = 1'b0;
            count_next  = CountIdle;
            event_out   = EV_DOUBLE;
        end
        else
        begin
            count_next = count_dec;
            if (count_dec == 0)
            begin
                event_out  = EV_SHORT;
                count_next = CountIdle;
            end
            hold_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg   <= '0;
            count_reg  <= '0;
            second_reg <= 1'b0;
        end
        else if (sample_en)
        begin
            hold_reg   <= hold_next;
            count_reg  <= count_next;
            second_reg <= second_next;
        end
    end

    // countdown never drops below idle
    a_count_floor: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg >= -1)
        else $error("double-click countdown below idle");

    a_long_idles: assert property (@(posedge clk) disable iff (!rst_n)
        sample_en && event_out == EV_LONG |=> count_reg == -1)
        else $error("long press did not idle the countdown");

    a_release_clears_hold: assert property (@(posedge clk) disable iff (!rst_n)
        sample_en && pin_level && !second_reg |=> hold_reg == '0)
        else $error("hold counter not cleared on release");

    a_hold_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        sample_en && !pin_level && hold_reg == HoldMax |=> hold_reg == HoldMax)
        else $error("hold counter wrapped");

endmodule

// File: src/bpc_out_stage.sv
// Output register holding one event until the downstream side takes it.
`timescale 1ns / 1ps

module bpc_out_stage
    import bpc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   load,
    input  event_t event_in,
    output logic   load_ready,
    output logic   out_valid,
    input  logic   out_ready,
    output event_t event_out
);

    logic   valid_reg;
    event_t event_reg;

    assign load_ready = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign event_out  = event_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load_ready)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && load_ready)
        begin
            event_reg <= event_in;
        end
    end

    a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !out_ready |=> valid_reg && $stable(event_reg))
        else $error("pending event lost while stalled");

    a_no_load_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !out_ready |-> !load_ready)
        else $error("ready raised while output stage full");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        load && load_ready |=> valid_reg)
        else $error("accepted transfer produced no event");

endmodule

// File: src/button_press_classifier_unit.sv
// Top level of the button press classifier: config registers, core and output stage.
`timescale 1ns / 1ps

// Each transfer on the slave side is one tick's pin sample (tdata bit 0, low
// means pressed); each yields exactly one event on the master side (tdata
// bits 2:0: none, pressed, short, double, long). Each accepted transfer
// updates the hold counter and the double-click countdown, and one output
// register separates the sides; throughput is one transfer per clock unless
// the master side stalls. Registers: index 0 is the double-click window in
// ticks (reset 40), index 1 the long-press threshold in ticks (reset 100);
// write them only while the block is idle.

module button_press_classifier_unit
    import bpc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     cfg_we,
    input  logic [CfgIndexWidth-1:0] cfg_index,
    input  logic [CfgDataWidth-1:0]  cfg_data,

    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [7:0]               s_tdata,   // [0] pin_level

    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [7:0]               m_tdata    // [2:0] event_res
);

    cfg_t   cfg_reg;
    event_t core_event;
    event_t out_event;
    logic   accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.double_window  <= WindowWidth'(40);
            cfg_reg.long_threshold <= ThresholdWidth'(100);
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                REG_DOUBLE_WINDOW:  cfg_reg.double_window  <= cfg_data[WindowWidth-1:0];
                REG_LONG_THRESHOLD: cfg_reg.long_threshold <= cfg_data[ThresholdWidth-1:0];
                default:            ;
            endcase
        end
    end

    assign accept = s_tvalid && s_tready;

    bpc_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .sample_en (accept),
        .pin_level (s_tdata[0]),
        .event_out (core_event)
    );

    bpc_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (s_tvalid),
        .event_in   (core_event),
        .load_ready (s_tready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .event_out  (out_event)
    );

    assign m_tdata = {5'b0, out_event};

endmodule

// File: sim/bpc_event_checker.sv
// Scoreboard for the button press classifier: predicts each tick's event and checks the output stream.
`timescale 1ns / 1ps

module bpc_event_checker
    import bpc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     cfg_we,
    input  logic [CfgIndexWidth-1:0] cfg_index,
    input  logic [CfgDataWidth-1:0]  cfg_data,

    input  logic                     s_tvalid,
    input  logic                     s_tready,
    input  logic [7:0]               s_tdata,   // [0] pin_level

    input  logic                     m_tvalid,
    input  logic                     m_tready,
    input  logic [7:0]               m_tdata,   // [2:0] event_res

    output int                       mismatch_count,
    output int                       pending
);

    logic [WindowWidth-1:0]        window_q;
    logic [ThresholdWidth-1:0]     threshold_q;
    logic [HoldWidth-1:0]          hold_q;
    logic signed [CountWidth-1:0]  countdown_q;
    logic                          second_q;

    event_t expected_events[$];

    // One tick of the classifier; pin low means pressed.
    function automatic event_t classify_tick(input logic pin);
        event_t ev;
        ev = EV_NONE;
        if (!pin)
        begin
            // a press reloads the window unless one is already running
            if (countdown_q <= 0 || countdown_q == $signed({1'b0, window_q}))
                countdown_q = {1'b0, window_q};
            else
                second_q = 1'b1;
            if (hold_q != HoldMax)
                hold_q = hold_q + 1'b1;
            if (hold_q >= threshold_q)
            begin
                ev          = EV_LONG;
                countdown_q = CountIdle;
            end
            else
                ev = EV_PRESSED;
        end
        else if (second_q)
        begin
            // hold counter is kept on the release that closes a double click
            second_q    = 1'b0;
            countdown_q = CountIdle;
            ev          = EV_DOUBLE;
        end
        else
        begin
            if (countdown_q >= 0)
                countdown_q = countdown_q - 1'b1;
            if (countdown_q == 0)
            begin
                ev          = EV_SHORT;
                countdown_q = CountIdle;
            end
            hold_q = '0;
        end
        return ev;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 100)
            $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        event_t want;
        if (!rst_n)
        begin
            window_q       = 10'd40;
            threshold_q    = 8'd100;
            hold_q         = '0;
            countdown_q    = '0;
            second_q       = 1'b0;
            mismatch_count = 0;
            expected_events.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_events.size() == 0)
                    report_mismatch($sformatf("event %0d with nothing expected",
                                              m_tdata[EventWidth-1:0]));
                else
                begin
                    want = expected_events.pop_front();
                    if (m_tdata[EventWidth-1:0] !== want)
                        report_mismatch($sformatf("event_res %0d, expected %s",
                                                  m_tdata[EventWidth-1:0], want.name()));
                    if (m_tdata[7:EventWidth] !== '0)
                        report_mismatch($sformatf("tdata padding %h not zero",
                                                  m_tdata[7:EventWidth]));
                end
            end
            if (s_tvalid && s_tready)
                expected_events.push_back(classify_tick(s_tdata[0]));
            if (cfg_we)
            begin
                case (cfg_index_t'(cfg_index))
                    REG_DOUBLE_WINDOW:  window_q    = cfg_data[WindowWidth-1:0];
                    REG_LONG_THRESHOLD: threshold_q = cfg_data[ThresholdWidth-1:0];
                    default: ;
                endcase
            end
        end
        pending = expected_events.size();
    end

endmodule

// File: sim/tb_button_press_classifier_unit.sv
// Testbench top for the button press classifier: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_button_press_classifier_unit;
    import bpc_pkg::*;

    localparam int RandomItems = 1900;
    localparam int PhaseItems  = 120;
    localparam int IdleLimit   = 500;   // cycles without any transfer

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [CfgIndexWidth-1:0] cfg_index;
    logic [CfgDataWidth-1:0]  cfg_data;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [7:0]               s_tdata;   // [0] pin_level
    logic                     m_tvalid;
    logic                     m_tready;
    logic [7:0]               m_tdata;   // [2:0] event_res

    int mismatch_count;
    int pending;
    int sent_count;
    bit steady;

    button_press_classifier_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    bpc_event_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatch_count),
        .pending        (pending)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // One pin sample per transfer; bits above the pin are noise.
    task automatic send_pin(input logic pin);
        int         gap;
        logic [6:0] noise;
        gap   = steady ? 0 : $urandom_range(0, 3);
        noise = 7'($urandom);
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {noise, pin};
        do
            @(posedge clk);
        while (!s_tready);
        sent_count++;
    endtask

    task automatic send_run(input logic pin, input int n);
        repeat (n)
            send_pin(pin);
    endtask

    // Stop sending and wait until every event has come back.
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic cfg_write(input cfg_index_t idx, input logic [CfgDataWidth-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Threshold writes carry random bits above the register width.
    task automatic set_threshold(input logic [ThresholdWidth-1:0] thr);
        logic [CfgDataWidth-1:0] word;
        word                      = CfgDataWidth'($urandom);
        word[ThresholdWidth-1:0]  = thr;
        cfg_write(REG_LONG_THRESHOLD, word);
    endtask

    // Release length: mostly inside or near the window, now and then waits it out.
    function automatic int release_len(input int win);
        int top;
        top = (win + 2 < 40) ? win + 2 : 40;
        if ($urandom_range(0, 5) == 0)
            return win + 1;
        return $urandom_range(0, top);
    endfunction

    task automatic click_sequence(input int win, input int thr);
        int kind;
        int i;
        kind = $urandom_range(0, 9);
        if (kind <= 3)
        begin
            send_run(1'b0, $urandom_range(1, 6));
            send_run(1'b1, release_len(win));
        end
        else if (kind <= 5)
        begin
            send_run(1'b0, $urandom_range(1, 4));
            send_run(1'b1, $urandom_range(0, (win < 6) ? win : 6));
            send_run(1'b0, $urandom_range(1, 4));
            send_run(1'b1, $urandom_range(1, 6));
        end
        else if (kind <= 7)
        begin
            // long press, sometimes past hold saturation when the threshold is high
            send_run(1'b0, thr + $urandom_range(0, 8));
            send_run(1'b1, $urandom_range(1, 4));
        end
        else if (kind == 8)
        begin
            for (i = $urandom_range(1, 10); i > 0; i--)
                send_pin(1'($urandom));
        end
        else
        begin
            repeat (3)
            begin
                send_run(1'b0, $urandom_range(1, 3));
                send_run(1'b1, $urandom_range(1, 3));
            end
        end
    endtask

    // Result side: random stall before each transfer.
    initial
    begin
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 3);
            repeat (stall)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
            end
            @(negedge clk);
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < IdleLimit)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle = 0;
            else
                idle++;
        end
        $display("button_press_classifier_unit verification failed");
        $finish;
    end

    initial
    begin
        int fixed_win [5];
        int fixed_thr [5];
        int phase;
        int win;
        int thr;
        int phase_start;
        fixed_win  = '{1023, 0, 1, 40, 7};
        fixed_thr  = '{255, 0, 1, 100, 5};
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        sent_count = 0;
        steady     = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // reset settings: one press and release, leaving the window open
        send_pin(1'b0);
        send_pin(1'b1);
        drain();
        cfg_write(REG_DOUBLE_WINDOW, 10'd3);
        set_threshold(8'd4);
        // press and release inside the still-running window, giving a double
        send_pin(1'b0);
        send_run(1'b1, 3);
        // double click
        send_pin(1'b0);
        send_pin(1'b1);
        send_pin(1'b0);
        send_pin(1'b1);
        // long press
        send_run(1'b0, 5);
        send_run(1'b1, 2);
        // window rewritten while the button is held
        send_pin(1'b0);
        drain();
        cfg_write(REG_DOUBLE_WINDOW, 10'd8);
        send_pin(1'b0);
        send_pin(1'b1);
        // zero window and zero threshold
        drain();
        cfg_write(REG_DOUBLE_WINDOW, 10'd0);
        cfg_write(REG_LONG_THRESHOLD, 10'h300);
        send_run(1'b0, 2);
        send_run(1'b1, 2);

        phase = 0;
        while (sent_count < RandomItems)
        begin
            win = (phase < 5) ? fixed_win[phase] : $urandom_range(0, 40);
            thr = (phase < 5) ? fixed_thr[phase] : $urandom_range(0, 30);
            drain();
            cfg_write(REG_DOUBLE_WINDOW, CfgDataWidth'(win));
            set_threshold(ThresholdWidth'(thr));
            steady      = ($urandom_range(0, 3) == 0);
            phase_start = sent_count;
            while (sent_count - phase_start < PhaseItems)
                click_sequence(win, thr);
            phase++;
        end
        drain();
        repeat (4) @(negedge clk);

        if (mismatch_count == 0)
            $display("button_press_classifier_unit verification clean");
        else
            $display("button_press_classifier_unit verification failed");
        $finish;
    end

endmodule

// File: button_press_classifier_unit.f
src/bpc_pkg.sv
src/bpc_core.sv
src/bpc_out_stage.sv
src/button_press_classifier_unit.sv
sim/bpc_event_checker.sv
sim/tb_button_press_classifier_unit.sv
